// File: rtl/core/stable_priority_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Stable priority queue assertion macros
// Shorthand for the concurrent checks of the stable priority queue unit.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("spq invariant violated");

// When the trigger holds, the consequence holds in the next cycle.
`define SPQ_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("spq sequence check failed");

`endif

// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Request and response types, status and action codes and the default capacity.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;

    localparam logic [1:0] STATUS_ENQUEUED  = 2'd0;
    localparam logic [1:0] STATUS_DEQUEUED  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    localparam logic ACTION_ENQUEUE = 1'b0;
    localparam logic ACTION_DEQUEUE = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] item_value;
        logic signed [15:0] priority_req;
    } spq_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic signed [15:0] out_priority;
    } spq_rsp_t;

endpackage

// File: rtl/core/stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Stable priority queue unit
// Bounded priority queue kept in sorted order in a simple dual-port memory.
// ----------------------------------------------------------------------------
// Usage: a request enters on req/req_valid/req_ready and carries an action,
// a value and a priority number. An enqueue places the item behind every
// stored entry whose priority number is less than or equal to its own, so
// lower numbers leave first and equal numbers leave in arrival order. A
// dequeue removes the front entry. Every request yields exactly one response
// on rsp/rsp_valid/rsp_ready with a status and, for a dequeue, the entry.
// Operation: the store is a circular buffer with a head pointer, so a
// dequeue is one memory read, taken as the request is accepted and passed
// through the result registers to the output register. An enqueue walks
// from the back of the queue toward the front, past every entry of
// higher priority number; each step is a registered memory read, then one
// signed compare and one write that moves the entry back by one place.
// Overflow and underflow go straight to the response state. The block
// takes one request at a time; req_ready is high when the sequencer is
// idle, and the next request may be accepted while the last response
// still waits. Reset empties the queue at once; the memory is not cleared,
// since only entries that have been written are ever read. If the receiver
// stalls, the response holds in the output register and a following
// finished request waits in its response state until the register frees.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_unit_macros.svh"

module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  spq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output spq_rsp_t rsp
);

    // AW indexes the memory; CW holds a count from zero up to CAPACITY.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ENQ_RD  = 3'd1;
    localparam logic [2:0] S_ENQ_CMP = 3'd2;
    localparam logic [2:0] S_DEQ     = 3'd3;
    localparam logic [2:0] S_RESP    = 3'd4;

    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_SUM   = SW'(CAPACITY);

    // Entry memory: value in the upper 32 bits, priority in the lower 16.
    logic [47:0] mem [CAPACITY];

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [15:0] prio_reg, prio_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic signed [31:0] res_value_reg, res_value_next;
    logic signed [15:0] res_prio_reg, res_prio_next;
    logic               rsp_valid_reg, rsp_valid_next;
    spq_rsp_t           rsp_reg, rsp_next;

    logic [47:0]        rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [47:0]        wr_data;
    logic [CW-1:0]      wr_pos;
    logic [CW-1:0]      rd_pos;
    logic               entry_later;

    // Logical position to physical address: head plus position, wrapped once.
    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                                 input logic [CW-1:0] pos);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(pos);
        if (sum >= CAP_SUM)
        begin
            sum = sum - CAP_SUM;
        end
        return sum[AW-1:0];
    endfunction

    assign rd_pos      = pos_reg - CW'(1);
    assign rd_addr     = (state_reg == S_ENQ_RD) ? phys_addr(head_reg, rd_pos) : head_reg;
    assign wr_addr     = phys_addr(head_reg, wr_pos);
    // The signed compare: does the stored entry sort behind the new item?
    assign entry_later = $signed(rd_data_reg[15:0]) > prio_reg;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        prio_next       = prio_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_prio_next   = res_prio_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        wr_pos          = pos_reg;
        wr_data         = {val_reg, prio_reg};

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    val_next       = req.item_value;
                    prio_next      = req.priority_req;
                    res_value_next = '0;
                    res_prio_next  = '0;
                    if (req.action == ACTION_ENQUEUE)
                    begin
                        if (count_reg == CAP_COUNT)
                        begin
                            res_status_next = STATUS_OVERFLOW;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            pos_next   = count_reg;
                            state_next = S_ENQ_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_UNDERFLOW;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            // The front entry is being read at this edge.
                            state_next = S_DEQ;
                        end
                    end
                end
            end
            S_ENQ_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we          = 1'b1;
                    count_next      = count_reg + CW'(1);
                    res_status_next = STATUS_ENQUEUED;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_ENQ_CMP;
                end
            end
            S_ENQ_CMP:
            begin
                mem_we = 1'b1;
                if (entry_later)
                begin
                    // Move the stored entry back one place and keep walking.
                    wr_data    = rd_data_reg;
                    pos_next   = rd_pos;
                    state_next = S_ENQ_RD;
                end
                else
                begin
                    count_next      = count_reg + CW'(1);
                    res_status_next = STATUS_ENQUEUED;
                    state_next      = S_RESP;
                end
            end
            S_DEQ:
            begin
                res_status_next = STATUS_DEQUEUED;
                res_value_next  = $signed(rd_data_reg[47:16]);
                res_prio_next   = $signed(rd_data_reg[15:0]);
                head_next       = phys_addr(head_reg, CW'(1));
                count_next      = count_reg - CW'(1);
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = res_status_reg;
                    rsp_next.out_value    = res_value_reg;
                    rsp_next.out_priority = res_prio_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        prio_reg       <= prio_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_prio_reg   <= res_prio_next;
        rsp_reg        <= rsp_next;
    end

    // The fill level never passes the capacity.
    `SPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CAP_COUNT)
    // While walking, the insertion point stays inside the filled region.
    `SPQ_ASSERT_ALWAYS(a_walk_range, (state_reg != S_ENQ_CMP) || (pos_reg != '0 && pos_reg <= count_reg))
    // The fill level only moves when a request finishes its memory work.
    `SPQ_ASSERT_NEXT(a_idle_count, state_reg == S_IDLE || state_reg == S_RESP, $stable(count_reg))
    // A dequeue that found entries always reports a dequeued status.
    `SPQ_ASSERT_NEXT(a_deq_status, state_reg == S_DEQ, res_status_reg == STATUS_DEQUEUED)

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Stable priority queue unit testbench
// Sends enqueue and dequeue requests with random gaps and response stalls.
// A sorted software copy of the queue predicts every response, and each
// accepted response is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench
    import spq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Software copy of the queue. Entries are kept sorted front to back. A new
    // entry goes behind every entry whose priority number is less than or
    // equal to its own. Each accepted request produces one predicted response,
    // and predictions are consumed in order as responses come out.
    class sorted_queue_tracker;
        typedef struct packed {
            logic signed [31:0] value;
            logic signed [15:0] prio;
        } held_entry_t;

        held_entry_t held_entries[$];
        spq_rsp_t    pending_responses[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Prints one line per mismatch and counts it.
        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        function int pending();
            return pending_responses.size();
        endfunction

        // Applies one accepted request to the copy and predicts its response.
        function void note_request(spq_req_t r);
            spq_rsp_t    want;
            held_entry_t slot;
            int          pos;

            want = '0;
            if (r.action == ACTION_ENQUEUE)
            begin
                if (held_entries.size() >= SPQ_CAPACITY)
                begin
                    want.status = STATUS_OVERFLOW;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_entries.size() &&
                           $signed(held_entries[pos].prio) <= $signed(r.priority_req))
                    begin
                        pos++;
                    end
                    slot.value = r.item_value;
                    slot.prio  = r.priority_req;
                    held_entries.insert(pos, slot);
                    want.status = STATUS_ENQUEUED;
                end
            end
            else if (held_entries.size() == 0)
            begin
                want.status = STATUS_UNDERFLOW;
            end
            else
            begin
                slot = held_entries.pop_front();
                want.status       = STATUS_DEQUEUED;
                want.out_value    = slot.value;
                want.out_priority = slot.prio;
            end
            pending_responses.push_back(want);
        endfunction

        // Compares one accepted response, field by field, with the oldest
        // prediction.
        task check_response(spq_rsp_t got);
            spq_rsp_t want;

            if (pending_responses.size() == 0)
            begin
                report_mismatch($sformatf("response with no request waiting, status %0d",
                                          got.status));
                return;
            end
            want = pending_responses.pop_front();
            if (got.status !== want.status)
            begin
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            end
            if (got.out_value !== want.out_value)
            begin
                report_mismatch($sformatf("out_value %h, expected %h",
                                          got.out_value, want.out_value));
            end
            if (got.out_priority !== want.out_priority)
            begin
                report_mismatch($sformatf("out_priority %h, expected %h",
                                          got.out_priority, want.out_priority));
            end
        endtask
    endclass

    // The longest correct stretch without any handshake is an enqueue that
    // walks past every stored entry, framed by the longest sender gap and
    // receiver stall. The limit leaves a wide margin over that.
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int MAX_WAIT      = 12;
    localparam int DRAIN_CYCLES  = 60;

    // Shapes of random bursts: mostly enqueues, mostly dequeues, or even.
    typedef enum int { MIX_FILLING, MIX_DRAINING, MIX_BALANCED } burst_mix_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    spq_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    spq_rsp_t rsp;

    sorted_queue_tracker board = new();

    // When set, the matching side runs without idling for a while.
    bit req_steady = 1'b0;
    bit rsp_steady = 1'b0;
    int idle_cycles = 0;

    stable_priority_queue_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Watchdog: any cycle without a request or a response handshake counts
    // toward the limit. Reaching it means the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offers one request after the given gap and waits until it is taken.
    // Valid stays high into the next request when the next gap is zero; it
    // drops only when a gap follows.
    task automatic send_request(input spq_req_t r, input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        board.note_request(r);
    endtask

    function automatic int sender_gap();
        return req_steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic send_fields(input logic act, input logic [31:0] value,
                               input logic [15:0] prio);
        spq_req_t r;

        r.action       = act;
        r.item_value   = value;
        r.priority_req = prio;
        send_request(r, sender_gap());
    endtask

    // Priorities lean toward a narrow band so that ties are common, with the
    // extremes and the full range mixed in.
    function automatic logic [15:0] draw_priority();
        int pick;

        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            return 16'($signed($urandom_range(0, 4)) - 2);
        end
        else if (pick < 6)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic spq_req_t draw_request(input burst_mix_t mix);
        spq_req_t r;
        int       roll;

        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILLING:  r.action = (roll < 80) ? ACTION_ENQUEUE : ACTION_DEQUEUE;
            MIX_DRAINING: r.action = (roll < 80) ? ACTION_DEQUEUE : ACTION_ENQUEUE;
            default:      r.action = (roll < 50) ? ACTION_ENQUEUE : ACTION_DEQUEUE;
        endcase
        // Dequeues carry random fields too, since the block must ignore them.
        r.item_value   = $urandom;
        r.priority_req = draw_priority();
        return r;
    endfunction

    // Response side: every response draws a stall, during which ready is low,
    // and then ready stays high until the response is taken. Now and then the
    // side switches into or out of a stretch with no stalls at all.
    initial
    begin : response_side
        int stall;

        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                rsp_steady = !rsp_steady;
            end
            stall = rsp_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            board.check_response(rsp);
        end
    end

    initial
    begin : request_side
        int         sent;
        int         burst_len;
        bit         paused_midway;
        burst_mix_t mix;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A dequeue from an empty queue underflows; its
        // ignored fields are nonzero on purpose.
        send_fields(ACTION_DEQUEUE, 32'hdead_beef, 16'h1234);

        // Extreme values and priorities, with two entries sharing a priority
        // number so that their arrival order must be kept.
        send_fields(ACTION_ENQUEUE, 32'h7fff_ffff, 16'sd5);
        send_fields(ACTION_ENQUEUE, 32'h8000_0000, 16'sd5);
        send_fields(ACTION_ENQUEUE, 32'h0000_0000, 16'h7fff);
        send_fields(ACTION_ENQUEUE, 32'hffff_ffff, 16'h8000);
        repeat (4) send_fields(ACTION_DEQUEUE, 32'h0, 16'h0);
        send_fields(ACTION_DEQUEUE, 32'h5555_aaaa, 16'haaaa);

        // Fill the store with falling priority numbers, so each new entry
        // walks past everything already held, then try one more: overflow.
        for (int i = 0; i < SPQ_CAPACITY; i++)
        begin
            send_fields(ACTION_ENQUEUE, 32'(i * 32'h0101_0101), 16'(1000 - i * 50));
        end
        send_fields(ACTION_ENQUEUE, 32'h1357_9bdf, 16'h8000);

        // Hold off until every response of the directed part has come back.
        req_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);

        // Random part in bursts, each with its own mix of actions and its own
        // idling mode on the request side.
        sent = 0;
        paused_midway = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            mix        = burst_mix_t'($urandom_range(0, 2));
            burst_len  = $urandom_range(8, 40);
            req_steady = ($urandom_range(0, 2) == 0);
            repeat (burst_len)
            begin
                send_request(draw_request(mix), sender_gap());
                sent++;
            end
            if (!paused_midway && sent >= RANDOM_ITEMS / 2)
            begin
                paused_midway = 1'b1;
                req_valid <= 1'b0;
                while (board.pending() != 0) @(posedge clk);
            end
        end

        req_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        // Leave time for any stray response to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/stable_priority_queue_unit.sv
verif/testbench.sv
